@@ design/dot_product_knn_topk_assert.svh @@
// Assertion macros for the dot product k-nearest block.
// Used by the top level; relies on the signals clock and reset in scope.
`ifndef DOT_PRODUCT_KNN_TOPK_ASSERT_SVH
`define DOT_PRODUCT_KNN_TOPK_ASSERT_SVH

// Same-cycle implication
`define DPK_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dpk: same-cycle check failed");

// Next-cycle implication
`define DPK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dpk: next-cycle check failed");

`endif

@@ design/dpk_pkg.sv @@
// Shared types and constants of the dot product k-nearest block.
// No dependencies; used by the interfaces, the kept-list chain and the top level.
package dpk_pkg;

   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 6;
   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 32;
   localparam int DIST_W     = 40;
   localparam int DOC_ID_W   = 32;
   localparam int VLEN_W     = 7;
   localparam int KEEP_W     = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   typedef logic [CMD_W-1:0]          cmd_type;
   typedef logic [INDEX_W-1:0]        index_type;
   typedef logic signed [ELEM_W-1:0]  elem_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [DIST_W-1:0]  dist_type;
   typedef logic [DOC_ID_W-1:0]       doc_id_type;

   // Request commands
   localparam cmd_type CMD_LOAD_QUERY = 2'd0;
   localparam cmd_type CMD_DOC_ELEM   = 2'd1;
   localparam cmd_type CMD_FLUSH      = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VECTOR_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_COUNT    = 1'd1;

   localparam logic [VLEN_W-1:0] VLEN_RESET = 7'd64;
   localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

   // 1.0 in Q.30
   localparam dist_type ONE_Q30 = 40'sh00_4000_0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_FLUSH
   } state_type;

   // Control broadcast to every cell of the kept list
   typedef struct packed {
      logic     insert_en;
      logic     shift_en;
      dist_type new_dist;
   } cell_ctrl_type;

   // Head of the kept list as seen by the control
   typedef struct packed {
      logic     head_valid;
      logic     second_valid;
      dist_type head_dist;
   } chain_status_type;

endpackage

@@ design/dpk_ifs.sv @@
// Request and response channel interfaces of the dot product k-nearest block.
// Depends on dpk_pkg for the payload types.
interface dpk_req_if import dpk_pkg::*; ;
   logic      valid;
   logic      ready;
   cmd_type   cmd;
   index_type elem_index;
   elem_type  elem_value;

   modport source (output valid, output cmd, output elem_index, output elem_value,
                   input ready);
   modport sink   (input valid, input cmd, input elem_index, input elem_value,
                   output ready);
endinterface

interface dpk_rsp_if import dpk_pkg::*; ;
   logic       valid;
   logic       ready;
   doc_id_type doc_id;
   dist_type   distance;
   logic       is_last;
   logic       is_empty;
   logic       partial_doc;

   modport source (output valid, output doc_id, output distance, output is_last,
                   output is_empty, output partial_doc, input ready);
   modport sink   (input valid, input doc_id, input distance, input is_last,
                   input is_empty, input partial_doc, output ready);
endinterface

@@ design/dpk_cell.sv @@
// One cell of the sorted kept list: holds one document id and distance.
// Depends on dpk_pkg; instantiated in a row by dpk_chain.
module dpk_cell import dpk_pkg::*; #(
   parameter int ID_W = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [ID_W-1:0] new_id,
   input  logic          in_range,
   input  logic          any_insert,
   input  logic          prev_valid,
   input  logic          prev_ins,
   input  dist_type      prev_dist,
   input  logic [ID_W-1:0] prev_id,
   input  logic          next_valid,
   input  dist_type      next_dist,
   input  logic [ID_W-1:0] next_id,
   output logic          valid_out,
   output logic          ins_out,
   output dist_type      dist_out,
   output logic [ID_W-1:0] id_out
);

   logic            valid_ff, valid_in;
   dist_type        dist_ff, dist_in;
   logic [ID_W-1:0] id_ff, id_in;

   // New entry belongs at or before this cell; ties go behind kept entries
   assign ins_out = in_range && (!valid_ff || (ctrl.new_dist < dist_ff));

   // Pick next content: shift toward the head, clear if out of range, take neighbour, take new, or hold
   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      id_in    = id_ff;
      if (ctrl.shift_en) begin
         valid_in = next_valid;
         dist_in  = next_dist;
         id_in    = next_id;
      end else if (ctrl.insert_en && any_insert) begin
         if (!in_range) begin
            valid_in = 1'b0;
         end else if (prev_ins) begin
            valid_in = prev_valid;
            dist_in  = prev_dist;
            id_in    = prev_id;
         end else if (ins_out) begin
            valid_in = 1'b1;
            dist_in  = ctrl.new_dist;
            id_in    = new_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      id_ff   <= id_in;
   end

   assign valid_out = valid_ff;
   assign dist_out  = dist_ff;
   assign id_out    = id_ff;

endmodule

@@ design/dpk_chain.sv @@
// Row of kept-list cells, sorted by ascending distance from the head.
// Depends on dpk_pkg and dpk_cell.
module dpk_chain import dpk_pkg::*; #(
   parameter int KEEP = 16,
   parameter int ID_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  logic [ID_W-1:0]  new_id,
   input  logic [KEEP-1:0]  keep_mask,
   output chain_status_type status,
   output logic [ID_W-1:0]  head_id
);

   // Padded neighbour links: slot 0 is before the head, slot KEEP+1 after the tail
   logic            valid_ext [KEEP+2];
   logic            ins_ext   [KEEP+2];
   dist_type        dist_ext  [KEEP+2];
   logic [ID_W-1:0] id_ext    [KEEP+2];
   logic [KEEP-1:0] ins_vec;
   logic            any_insert;

   assign valid_ext[0]      = 1'b0;
   assign ins_ext[0]        = 1'b0;
   assign dist_ext[0]       = '0;
   assign id_ext[0]         = '0;
   assign valid_ext[KEEP+1] = 1'b0;
   assign ins_ext[KEEP+1]   = 1'b0;
   assign dist_ext[KEEP+1]  = '0;
   assign id_ext[KEEP+1]    = '0;

   for (genvar g = 0; g < KEEP; g++) begin : g_cell
      dpk_cell #(.ID_W(ID_W)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_id     (new_id),
         .in_range   (keep_mask[g]),
         .any_insert (any_insert),
         .prev_valid (valid_ext[g]),
         .prev_ins   (ins_ext[g]),
         .prev_dist  (dist_ext[g]),
         .prev_id    (id_ext[g]),
         .next_valid (valid_ext[g+2]),
         .next_dist  (dist_ext[g+2]),
         .next_id    (id_ext[g+2]),
         .valid_out  (valid_ext[g+1]),
         .ins_out    (ins_ext[g+1]),
         .dist_out   (dist_ext[g+1]),
         .id_out     (id_ext[g+1])
      );
      assign ins_vec[g] = ins_ext[g+1];
   end

   // Drop the new entry unless some in-range cell takes it
   assign any_insert = |ins_vec;

   assign status.head_valid   = valid_ext[1];
   assign status.second_valid = valid_ext[2];
   assign status.head_dist    = dist_ext[1];
   assign head_id             = id_ext[1];

endmodule

@@ design/dot_product_knn_topk.sv @@
// Load query element: written while idle, with no further state. Document element: from acceptance to the next
// acceptance it passes query memory read, multiply and accumulate; the kept-list insert follows
// in the cell row, overlapped with the next request. Flush: enters the flush state, then one result
// per cycle the sink accepts, the row shifting toward its head.
// Reset is synchronous: it clears control, accumulator, id counter and kept list at once;
// the query memory keeps its contents and needs no clearing pass.
`include "dot_product_knn_topk_assert.svh"

module dot_product_knn_topk import dpk_pkg::*; #(
   parameter int MAX_DIM  = 64,
   parameter int MAX_KEEP = 16,
   parameter int ID_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   dpk_req_if.sink                req_if,
   dpk_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   state_type           state_ff, state_in;
   logic [VLEN_W-1:0]   vlen_ff;
   logic [KEEP_W-1:0]   keep_ff;
   logic [31:0]         eff_len;
   logic [31:0]         eff_keep;
   logic [MAX_KEEP-1:0] keep_mask;

   elem_type            qmem [MAX_DIM];
   elem_type            qrd_ff;
   elem_type            value_ff;
   prod_type            prod_ff;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    wr_addr;
   logic                idx_ok;
   dist_type            rem_ff, rem_in;
   dist_type            sum_acc;
   logic                doc_end;
   logic [ID_WIDTH-1:0] next_id_ff, next_id_in;
   logic                ins_req_ff, ins_req_in;
   dist_type            ins_dist_ff;
   logic [ID_WIDTH-1:0] ins_id_ff;
   logic                partial_ff;

   logic                req_accept;
   logic                rsp_load;
   logic                rsp_last_in;
   logic                rsp_valid_ff;
   doc_id_type          rsp_doc_id_ff;
   dist_type            rsp_dist_ff;
   logic                rsp_last_ff;
   logic                rsp_empty_ff;
   logic                rsp_partial_ff;

   cell_ctrl_type       cell_ctrl;
   chain_status_type    status;
   logic [ID_WIDTH-1:0] head_id;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= VLEN_RESET;
         keep_ff <= KEEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VECTOR_LENGTH: vlen_ff <= csr_wdata[VLEN_W-1:0];
            CSR_KEEP_COUNT:    keep_ff <= csr_wdata[KEEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate register values into their usable ranges
   always_comb begin
      if (vlen_ff == '0) begin
         eff_len = 32'd1;
      end else if (32'(vlen_ff) > 32'(MAX_DIM)) begin
         eff_len = 32'(MAX_DIM);
      end else begin
         eff_len = 32'(vlen_ff);
      end
      if (keep_ff == '0) begin
         eff_keep = 32'd1;
      end else if (32'(keep_ff) > 32'(MAX_KEEP)) begin
         eff_keep = 32'(MAX_KEEP);
      end else begin
         eff_keep = 32'(keep_ff);
      end
   end

   for (genvar g = 0; g < MAX_KEEP; g++) begin : g_keep
      assign keep_mask[g] = (32'(g) < eff_keep);
   end

   assign req_accept = req_if.valid && req_if.ready;
   assign idx_ok     = (32'(req_if.elem_index) < 32'(MAX_DIM));
   assign wr_addr    = POS_W'(req_if.elem_index);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_if.cmd)
                  CMD_DOC_ELEM: state_in = ST_MUL;
                  CMD_FLUSH:    state_in = ST_FLUSH;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_IDLE;
         ST_FLUSH: begin
            if (rsp_load && rsp_last_in) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      rsp_load     = (state_ff == ST_FLUSH) && (!rsp_valid_ff || rsp_if.ready);
      rsp_last_in  = !status.head_valid || !status.second_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Query memory: write on load, registered read on document element
   always_ff @(posedge clock) begin
      if (req_accept && (req_if.cmd == CMD_LOAD_QUERY) && idx_ok) begin
         qmem[wr_addr] <= req_if.elem_value;
      end
      if (req_accept && (req_if.cmd == CMD_DOC_ELEM)) begin
         qrd_ff   <= qmem[pos_ff];
         value_ff <= req_if.elem_value;
      end
   end

   // Multiply stage
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= qrd_ff * value_ff;
      end
   end

   // Accumulate the distance directly: start at one, subtract each product
   assign sum_acc = rem_ff - DIST_W'(prod_ff);
   assign doc_end = ((32'(pos_ff) + 32'd1) >= eff_len);

   always_comb begin
      pos_in     = pos_ff;
      rem_in     = rem_ff;
      next_id_in = next_id_ff;
      ins_req_in = 1'b0;
      if (state_ff == ST_ACC) begin
         if (doc_end) begin
            pos_in     = '0;
            rem_in     = ONE_Q30;
            next_id_in = next_id_ff + ID_WIDTH'(1);
            ins_req_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            rem_in = sum_acc;
         end
      end
      if (req_accept && (req_if.cmd == CMD_FLUSH)) begin
         pos_in     = '0;
         rem_in     = ONE_Q30;
         next_id_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         rem_ff     <= ONE_Q30;
         next_id_ff <= '0;
         ins_req_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         rem_ff     <= rem_in;
         next_id_ff <= next_id_in;
         ins_req_ff <= ins_req_in;
      end
   end

   // Hold the finished document for the insert into the cell row
   always_ff @(posedge clock) begin
      if ((state_ff == ST_ACC) && doc_end) begin
         ins_dist_ff <= sum_acc;
         ins_id_ff   <= next_id_ff;
      end
      if (req_accept && (req_if.cmd == CMD_FLUSH)) begin
         partial_ff <= (pos_ff != '0);
      end
   end

   assign cell_ctrl.insert_en = ins_req_ff;
   assign cell_ctrl.shift_en  = rsp_load;
   assign cell_ctrl.new_dist  = ins_dist_ff;

   dpk_chain #(.KEEP(MAX_KEEP), .ID_W(ID_WIDTH)) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cell_ctrl),
      .new_id    (ins_id_ff),
      .keep_mask (keep_mask),
      .status    (status),
      .head_id   (head_id)
   );

   // Response register: load from the head of the row, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_doc_id_ff  <= status.head_valid ? DOC_ID_W'(head_id) : '0;
         rsp_dist_ff    <= status.head_valid ? status.head_dist : '0;
         rsp_last_ff    <= rsp_last_in;
         rsp_empty_ff   <= !status.head_valid;
         rsp_partial_ff <= partial_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.doc_id      = rsp_doc_id_ff;
   assign rsp_if.distance    = rsp_dist_ff;
   assign rsp_if.is_last     = rsp_last_ff;
   assign rsp_if.is_empty    = rsp_empty_ff;
   assign rsp_if.partial_doc = rsp_partial_ff;

   // The last result of a flush leaves the row empty
   `DPK_ASSERT_NEXT(a_flush_drains, rsp_load && rsp_last_in, !status.head_valid)
   // An insert and a flush shift never meet in the row
   `DPK_ASSERT_SAME(a_insert_not_in_flush, ins_req_ff, !rsp_load)
   // A finished document restarts the position and the sum and issues an insert
   `DPK_ASSERT_NEXT(a_doc_end_restarts, (state_ff == ST_ACC) && doc_end,
                    (pos_ff == '0) && ins_req_ff && (rem_ff == ONE_Q30))

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for dot_product_knn_topk: drives query, document and flush
// requests, ranks documents in a local copy of the top-k list and checks every neighbour.
// Depends on dpk_pkg, dpk_req_if / dpk_rsp_if and the block's top level.
`timescale 1ns / 1ps

module tb_top;
   import dpk_pkg::*;

   localparam int          MAX_DIM      = 64;
   localparam int          MAX_KEEP     = 16;
   localparam cmd_type     CMD_UNUSED   = 2'd3;
   localparam int unsigned SETTLE       = 10;
   localparam int unsigned RANDOM_ITEMS = 40;

   typedef struct {
      doc_id_type doc_id;
      dist_type   distance;
      logic       is_last;
      logic       is_empty;
      logic       partial_doc;
   } neighbour_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   dpk_req_if req_chan ();
   dpk_rsp_if rsp_chan ();

   dot_product_knn_topk i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the ranking state
   elem_type          query_mem [MAX_DIM];
   dist_type          dot_acc;
   int unsigned       elem_pos;
   doc_id_type        next_id;
   doc_id_type        kept_id   [MAX_KEEP];
   dist_type          kept_dist [MAX_KEEP];
   int unsigned       kept_n;
   logic [VLEN_W-1:0] vlen_reg;
   logic [KEEP_W-1:0] keep_reg;

   neighbour_type due_neighbours [$];
   int unsigned   error_count;
   int            burst_left;

   // Response stall pattern and the long hold-off
   logic [15:0] stall_mask;
   int unsigned stall_step;
   logic        holding;
   int unsigned hold_len;
   event        hold_start;

   initial begin : clock_gen
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : run_limit
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int unsigned eff_len();
      if (vlen_reg == 0) return 1;
      if (vlen_reg > MAX_DIM) return MAX_DIM;
      return vlen_reg;
   endfunction

   function automatic int unsigned eff_keep();
      if (keep_reg == 0) return 1;
      if (keep_reg > MAX_KEEP) return MAX_KEEP;
      return keep_reg;
   endfunction

   // Insert a finished document; ties go behind, the later equal maximum is evicted
   function automatic void rank_document(doc_id_type id, dist_type doc_dist);
      int unsigned k;
      int unsigned n;
      int unsigned p;
      k = eff_keep();
      n = (kept_n < k) ? kept_n : k;
      p = 0;
      while (p < n && kept_dist[p] <= doc_dist) p++;
      if (p >= k) return;
      if (n >= k) n = k - 1;
      for (int unsigned i = n; i > p; i--) begin
         kept_dist[i] = kept_dist[i-1];
         kept_id[i]   = kept_id[i-1];
      end
      kept_dist[p] = doc_dist;
      kept_id[p]   = id;
      kept_n       = n + 1;
   endfunction

   // Advance the ranking state by one accepted request; queue the neighbours it releases
   function automatic void rank_update(cmd_type c, index_type idx, elem_type v);
      int unsigned   pos;
      prod_type      prod;
      logic          part;
      neighbour_type nb;
      case (c)
         CMD_LOAD_QUERY: begin
            query_mem[idx] = v;
         end
         CMD_DOC_ELEM: begin
            pos = (elem_pos >= MAX_DIM) ? MAX_DIM - 1 : elem_pos;
            prod = query_mem[pos] * v;
            dot_acc = dot_acc + dist_type'(prod);
            if (elem_pos + 1 >= eff_len()) begin
               rank_document(next_id, ONE_Q30 - dot_acc);
               next_id++;
               dot_acc  = '0;
               elem_pos = 0;
            end else begin
               elem_pos++;
            end
         end
         CMD_FLUSH: begin
            part = (elem_pos != 0);
            if (kept_n == 0) begin
               nb.doc_id      = '0;
               nb.distance    = '0;
               nb.is_last     = 1'b1;
               nb.is_empty    = 1'b1;
               nb.partial_doc = part;
               due_neighbours.push_back(nb);
            end else begin
               for (int unsigned i = 0; i < kept_n; i++) begin
                  nb.doc_id      = kept_id[i];
                  nb.distance    = kept_dist[i];
                  nb.is_last     = (i + 1 == kept_n);
                  nb.is_empty    = 1'b0;
                  nb.partial_doc = part;
                  due_neighbours.push_back(nb);
               end
            end
            dot_acc  = '0;
            elem_pos = 0;
            kept_n   = 0;
            next_id  = '0;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Offer one request in bursts with random gaps; update the ranking once accepted
   task automatic send_request(cmd_type c, index_type idx, elem_type v);
      if (burst_left <= 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= c;
      req_chan.elem_index <= idx;
      req_chan.elem_value <= v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
      rank_update(c, idx, v);
   endtask

   function automatic elem_type pick_value();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         default: return elem_type'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_element(elem_type v);
      send_request(CMD_DOC_ELEM, index_type'($urandom_range(0, 63)), v);
   endtask

   task automatic flush_results();
      send_request(CMD_FLUSH, index_type'($urandom_range(0, 63)),
                   elem_type'($urandom_range(0, 65535)));
   endtask

   // Drop valid, wait for every due neighbour, then let the block settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (due_neighbours.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_VECTOR_LENGTH) vlen_reg = data[VLEN_W-1:0];
      else                          keep_reg = data[KEEP_W-1:0];
   endtask

   // Flush with nothing kept, around an unused command
   task automatic test_empty_flush();
      send_request(CMD_UNUSED, 6'd63, 16'sh8000);
      flush_results();
      send_request(CMD_UNUSED, 6'd0, 16'sh7FFF);
   endtask

   // Fill every query position, extremes first
   task automatic test_load_query();
      elem_type v;
      for (int i = 0; i < MAX_DIM; i++) begin
         case (i)
            0:       v = 16'sh7FFF;
            1:       v = 16'sh8000;
            2:       v = -16'sd1;
            3:       v = 16'sh0000;
            default: v = pick_value();
         endcase
         send_request(CMD_LOAD_QUERY, index_type'(i), v);
      end
   endtask

   // Full-length document opened at the reset length, closed at a saturated length
   task automatic test_full_length();
      elem_type v;
      for (int i = 0; i < MAX_DIM; i++) begin
         case (i % 4)
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            default: v = pick_value();
         endcase
         if (i == MAX_DIM - 4) write_register(CSR_VECTOR_LENGTH, 7'd127);
         send_element(v);
      end
      flush_results();
   endtask

   // Equal distances keep arrival order; a strictly smaller one evicts the later maximum
   task automatic test_ties();
      write_register(CSR_VECTOR_LENGTH, 7'd1);
      write_register(CSR_KEEP_COUNT, 7'd2);
      send_element(16'sd0);
      send_element(16'sd0);
      send_element(16'sd0);
      send_element(16'sd100);
      send_element(16'sd0);
      send_element(16'sh8000);
      flush_results();
   endtask

   // Lower the keep count with a full list, then sweep its extremes
   task automatic test_keep_lowered();
      write_register(CSR_KEEP_COUNT, 7'd4);
      send_element(-16'sd5000);
      send_element(16'sd20000);
      send_element(16'sd0);
      send_element(16'sh7FFF);
      write_register(CSR_KEEP_COUNT, 7'd2);
      flush_results();
      write_register(CSR_KEEP_COUNT, 7'd4);
      send_element(16'sd1000);
      send_element(16'sd2000);
      send_element(16'sd3000);
      send_element(16'sd4000);
      write_register(CSR_KEEP_COUNT, 7'd2);
      send_element(16'sd500);
      flush_results();
      write_register(CSR_KEEP_COUNT, 7'd0);
      repeat (3) send_element(pick_value());
      flush_results();
      write_register(CSR_KEEP_COUNT, 7'd31);
      repeat (5) send_element(pick_value());
      flush_results();
   endtask

   // Flush with a document half-way through, with and without kept entries
   task automatic test_partial_flush();
      write_register(CSR_VECTOR_LENGTH, 7'd3);
      write_register(CSR_KEEP_COUNT, 7'd4);
      repeat (8) send_element(pick_value());
      flush_results();
      send_element(pick_value());
      flush_results();
   endtask

   // Shorten the length while a document is open
   task automatic test_length_change();
      write_register(CSR_VECTOR_LENGTH, 7'd5);
      repeat (3) send_element(pick_value());
      write_register(CSR_VECTOR_LENGTH, 7'd2);
      repeat (3) send_element(pick_value());
      flush_results();
      write_register(CSR_VECTOR_LENGTH, 7'd0);
      repeat (2) send_element(pick_value());
      flush_results();
   endtask

   // Hold the response side off while requests keep coming, so the input backs up
   task automatic test_stalled_output();
      write_register(CSR_VECTOR_LENGTH, 7'd1);
      write_register(CSR_KEEP_COUNT, 7'd16);
      repeat (16) send_element(pick_value());
      hold_len = 300;
      -> hold_start;
      flush_results();
      repeat (8) send_element(pick_value());
      flush_results();
   endtask

   // Rounds of random settings, documents with noise, broken documents and flushes
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned len;
      int unsigned cut;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       write_register(CSR_VECTOR_LENGTH, 7'd0);
            1:       write_register(CSR_VECTOR_LENGTH, CSR_DATA_W'($urandom_range(7, 12)));
            default: write_register(CSR_VECTOR_LENGTH, CSR_DATA_W'($urandom_range(1, 6)));
         endcase
         if ($urandom_range(0, 3) == 0)
            write_register(CSR_KEEP_COUNT, CSR_DATA_W'($urandom_range(0, 127)));
         else
            write_register(CSR_KEEP_COUNT, CSR_DATA_W'($urandom_range(1, 5)));
         len = eff_len();
         repeat ($urandom_range(1, 10)) begin
            for (int e = 0; e < len; e++) begin
               case ($urandom_range(0, 19))
                  0: send_request(CMD_UNUSED, index_type'($urandom_range(0, 63)),
                                  pick_value());
                  1: begin
                     send_request(CMD_LOAD_QUERY, index_type'($urandom_range(0, 63)),
                                  pick_value());
                     sent++;
                  end
                  default: begin
                  end
               endcase
               send_element(pick_value());
               sent++;
            end
         end
         case ($urandom_range(0, 9))
            0, 1: begin
               cut = (len > 1) ? $urandom_range(1, len - 1) : 0;
               repeat (cut) send_element(pick_value());
               flush_results();
               sent += cut + 1;
            end
            2: begin
               // leave the list and any open document to the next settings
               if (len > 1) begin
                  cut = $urandom_range(1, len - 1);
                  repeat (cut) send_element(pick_value());
                  sent += cut;
               end
            end
            default: begin
               flush_results();
               sent++;
            end
         endcase
      end
      flush_results();
   endtask

   initial begin : rsp_hold_off
      holding = 1'b0;
      forever begin
         @(hold_start);
         holding <= 1'b1;
         repeat (hold_len) @(posedge clock);
         holding <= 1'b0;
      end
   end

   // Receiver stalls on a 16-bit mask, redrawn each window, often fully open
   always @(posedge clock) begin : rsp_stall_pattern
      if (stall_step == 15) begin
         stall_step <= 0;
         stall_mask <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end else begin
         stall_step <= stall_step + 1;
      end
      rsp_chan.ready <= !reset && !holding && stall_mask[stall_step];
   end

   // Compare each accepted neighbour with the oldest one due
   always @(posedge clock) begin : check_neighbour
      neighbour_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (due_neighbours.size() == 0) begin
            report_mismatch("neighbour with none due", 64'(rsp_chan.doc_id), '0);
         end else begin
            want = due_neighbours.pop_front();
            if (rsp_chan.doc_id !== want.doc_id)
               report_mismatch("doc_id", 64'(rsp_chan.doc_id), 64'(want.doc_id));
            if (rsp_chan.distance !== want.distance)
               report_mismatch("distance", 64'(rsp_chan.distance), 64'(want.distance));
            if (rsp_chan.is_last !== want.is_last)
               report_mismatch("is_last", 64'(rsp_chan.is_last), 64'(want.is_last));
            if (rsp_chan.is_empty !== want.is_empty)
               report_mismatch("is_empty", 64'(rsp_chan.is_empty), 64'(want.is_empty));
            if (rsp_chan.partial_doc !== want.partial_doc)
               report_mismatch("partial_doc", 64'(rsp_chan.partial_doc),
                               64'(want.partial_doc));
         end
      end
   end

   initial begin : test_sequence
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_LOAD_QUERY;
      req_chan.elem_index = '0;
      req_chan.elem_value = '0;
      rsp_chan.ready      = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_VECTOR_LENGTH;
      csr_wdata           = '0;
      stall_mask          = 16'hFFFF;
      stall_step          = 0;
      hold_len            = 0;
      error_count         = 0;
      burst_left          = 0;
      dot_acc             = '0;
      elem_pos            = 0;
      next_id             = '0;
      kept_n              = 0;
      vlen_reg            = VLEN_RESET;
      keep_reg            = KEEP_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_flush();
      test_load_query();
      test_full_length();
      test_ties();
      test_keep_lowered();
      test_partial_flush();
      test_length_change();
      test_stalled_output();
      test_random_traffic();
      drain();

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
